/* hdl/dvsc_pkg.sv */
// Shared types and constants for the delayed valve supply controller.
package dvsc_pkg;

  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned CfgIndexWidth     = 2;
  localparam int unsigned ProcessStateCodes = 16;
  localparam int unsigned DelayLimit        = 60 * 1000;

  localparam logic [CfgWidth-1:0] ResetOpenDelay  = 16'd200;
  localparam logic [CfgWidth-1:0] ResetCloseDelay = 16'd0;
  localparam logic [CfgWidth-1:0] ResetActiveMask = 16'd252;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_OPEN_DELAY  = 2'd0,
    CFG_CLOSE_DELAY = 2'd1,
    CFG_ACTIVE_MASK = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PROC  = 2'd1,
    OP_LEVEL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INACTIVE  = 2'd0,
    ST_IDLE      = 2'd1,
    ST_DLY_OPEN  = 2'd2,
    ST_DLY_CLOSE = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] process_state;
    logic       level_high;
  } in_item_t;

  typedef struct packed {
    logic       valve_open;
    logic       valve_commanded;
    logic [1:0] controller_state;
  } out_item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] open_delay_ms;
    logic [CfgWidth-1:0] close_delay_ms;
    logic [CfgWidth-1:0] active_state_mask;
  } cfg_t;

endpackage

/* hdl/dvsc_cfg.sv */
// Configuration register file: open delay, close delay, active mask.
module dvsc_cfg import dvsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OPEN_DELAY:  cfg_d.open_delay_ms     = cfg_wdata_i;
        CFG_CLOSE_DELAY: cfg_d.close_delay_ms    = cfg_wdata_i;
        CFG_ACTIVE_MASK: cfg_d.active_state_mask = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_delay_ms     <= ResetOpenDelay;
      cfg_q.close_delay_ms    <= ResetCloseDelay;
      cfg_q.active_state_mask <= ResetActiveMask;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/dvsc_core.sv */
// Controller state machine with delay countdown; computes one result per item.
module dvsc_core import dvsc_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam int unsigned CapValue = (DELAY_WIDTH >= 16) ? DelayLimit
                                                          : ((2 ** DELAY_WIDTH) - 1);
  localparam logic [DELAY_WIDTH-1:0] DelayCap = DELAY_WIDTH'(CapValue);

  ctrl_state_e            state_q, state_d;
  logic [DELAY_WIDTH-1:0] cnt_q, cnt_d;
  logic [3:0]             last_q, last_d;
  logic                   level_q, level_d;
  logic                   drive_q, drive_d;
  logic                   cmd;
  logic                   was_active, now_active;

  function automatic logic [DELAY_WIDTH-1:0] load_delay(input logic [CfgWidth-1:0] d);
    logic [DELAY_WIDTH-1:0] r;
    if (32'(d) > CapValue) r = DelayCap;
    else                   r = DELAY_WIDTH'(d);
    return r;
  endfunction

  function automatic logic code_active(input logic [3:0] code,
                                       input logic [CfgWidth-1:0] mask);
    return (32'(code) < ProcessStateCodes) && mask[code];
  endfunction

  assign was_active = code_active(last_q, cfg_i.active_state_mask);
  assign now_active = code_active(item_i.process_state, cfg_i.active_state_mask);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    level_d = level_q;
    drive_d = drive_q;
    cmd     = 1'b0;
    if (accept_i) begin
      unique case (item_i.opcode)
        OP_TICK: begin
          if (state_q == ST_DLY_OPEN || state_q == ST_DLY_CLOSE) begin
            if (cnt_q <= DELAY_WIDTH'(1)) begin
              cnt_d   = '0;
              drive_d = (state_q == ST_DLY_OPEN);
              cmd     = 1'b1;
              state_d = ST_IDLE;
            end else begin
              cnt_d = cnt_q - DELAY_WIDTH'(1);
            end
          end
        end
        OP_PROC: begin
          if (item_i.process_state != last_q) begin
            last_d = item_i.process_state;
            if (was_active != now_active) begin
              if (now_active) begin
                if (state_q == ST_INACTIVE) begin
                  // leaving inactive: valve opens if the level is low, closes if it is high
                  state_d = ST_IDLE;
                  drive_d = !level_q;
                  cmd     = 1'b1;
                end
              end else if (state_q != ST_INACTIVE) begin
                state_d = ST_INACTIVE;
                cnt_d   = '0;
                drive_d = 1'b0;
                cmd     = 1'b1;
              end
            end
          end
        end
        OP_LEVEL: begin
          if (item_i.level_high != level_q) begin
            level_d = item_i.level_high;
            if (state_q == ST_IDLE) begin
              if (item_i.level_high) begin
                state_d = ST_DLY_CLOSE;
                cnt_d   = load_delay(cfg_i.close_delay_ms);
              end else begin
                state_d = ST_DLY_OPEN;
                cnt_d   = load_delay(cfg_i.open_delay_ms);
              end
            end else if (state_q != ST_INACTIVE) begin
              // level change cancels a pending delay
              state_d = ST_IDLE;
              cnt_d   = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INACTIVE;
      cnt_q   <= '0;
      last_q  <= '0;
      level_q <= 1'b0;
      drive_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      level_q <= level_d;
      drive_q <= drive_d;
    end
  end

  assign result_o.valve_open       = drive_d;
  assign result_o.valve_commanded  = cmd;
  assign result_o.controller_state = state_d;

endmodule

/* hdl/dvsc_out.sv */
// Result register with skid stage so input is taken while a result waits.
module dvsc_out import dvsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic      main_v_q, main_v_d;
  logic      skid_v_q, skid_v_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = main_v_q && !out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    priority if (skid_v_q && pop) begin
      main_d   = skid_q;
      skid_v_d = 1'b0;
    end else if (!main_v_q || pop) begin
      main_v_d = push_i;
      main_d   = item_i;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_item_o  = main_q;

endmodule

/* hdl/delayed_valve_supply_controller.sv */
// A result is registered in the result stage when its item is accepted.
// Throughput: one item per cycle while the input is not stalled; the state update is a single registered pass.
// A two-deep result stage takes one more item while the output stalls; input then
// stalls from the next cycle until the waiting result is taken.
// Reset (async, active low): inactive, countdown 0, valve closed, level 0,
// process code 0, registers at open 200, close 0, mask 252; no results pending.
module delayed_valve_supply_controller import dvsc_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_wdata_i
);

  cfg_t      cfg;
  out_item_t result;
  logic      accept;
  logic      full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dvsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dvsc_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  dvsc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .item_i      (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the delayed valve supply controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dvsc_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RAND_PHASES    = 10;
  localparam int         PHASE_ITEMS    = 190;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         WATCHDOG_LIMIT = 5000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    in_item_t            item;
    bit                  typed;
    out_item_t           want;
    cfg_index_e          idx;
    logic [CfgWidth-1:0] val;
  } row_t;

  logic                     clk_i;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  in_item_t                 in_item   = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_OPEN_DELAY;
  logic [CfgWidth-1:0]      cfg_wdata = '0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  out_item_t                out_item_o;

  // predictor state and its copy of the registers
  ctrl_state_e         pv_state;
  logic [15:0]         pv_count;
  logic [3:0]          pv_code;
  logic                pv_level;
  logic                pv_valve;
  logic                pv_cmd;
  logic [CfgWidth-1:0] cfg_open;
  logic [CfgWidth-1:0] cfg_close;
  logic [CfgWidth-1:0] cfg_mask;

  out_item_t valve_result_q[$];
  row_t      dir_rows[$];
  int        err_cnt     = 0;
  int        idle_cycles = 0;
  int        tx_gap_pct  = 15;
  int        rx_gap_pct  = 10;
  bit        hold_armed  = 1'b0;

  delayed_valve_supply_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] capped(logic [CfgWidth-1:0] d);
    return (d > DelayLimit) ? 16'(DelayLimit) : d;
  endfunction

  function automatic logic code_on(logic [3:0] c);
    if (c >= ProcessStateCodes) return 1'b0;
    return cfg_mask[c];
  endfunction

  function automatic void move_to(ctrl_state_e nxt);
    if (nxt == pv_state) return;
    // leaving inactive sets the valve from the level
    if (pv_state == ST_INACTIVE) begin
      pv_valve = ~pv_level;
      pv_cmd   = 1'b1;
    end
    if (pv_state == ST_DLY_OPEN || pv_state == ST_DLY_CLOSE) pv_count = '0;
    pv_state = nxt;
    case (nxt)
      ST_INACTIVE: begin
        pv_valve = 1'b0;
        pv_cmd   = 1'b1;
      end
      ST_DLY_OPEN:  pv_count = capped(cfg_open);
      ST_DLY_CLOSE: pv_count = capped(cfg_close);
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_valve(in_item_t it);
    out_item_t res;
    logic      was_on;
    logic      now_on;
    pv_cmd = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        if (pv_state == ST_DLY_OPEN || pv_state == ST_DLY_CLOSE) begin
          if (pv_count <= 16'd1) begin
            pv_count = '0;
            pv_valve = (pv_state == ST_DLY_OPEN);
            pv_cmd   = 1'b1;
            move_to(ST_IDLE);
          end else begin
            pv_count = pv_count - 16'd1;
          end
        end
      end
      OP_PROC: begin
        if (it.process_state != pv_code) begin
          was_on = code_on(pv_code);
          now_on = code_on(it.process_state);
          if (was_on != now_on) begin
            if (now_on) begin
              if (pv_state == ST_INACTIVE) move_to(ST_IDLE);
            end else if (pv_state != ST_INACTIVE) begin
              move_to(ST_INACTIVE);
            end
          end
          pv_code = it.process_state;
        end
      end
      OP_LEVEL: begin
        if (it.level_high != pv_level) begin
          pv_level = it.level_high;
          if (pv_state == ST_IDLE) move_to(pv_level ? ST_DLY_CLOSE : ST_DLY_OPEN);
          else if (pv_state != ST_INACTIVE) move_to(ST_IDLE);
        end
      end
      default: ;
    endcase
    res.valve_open       = pv_valve;
    res.valve_commanded  = pv_cmd;
    res.controller_state = pv_state;
    return res;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, logic [3:0] code, logic lvl);
    in_item_t it;
    it.opcode        = op;
    it.process_state = code;
    it.level_high    = lvl;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic v, logic c, ctrl_state_e st);
    out_item_t o;
    o.valve_open       = v;
    o.valve_commanded  = c;
    o.controller_state = st;
    return o;
  endfunction

  function automatic row_t row_in(in_item_t it, bit typed, out_item_t want);
    row_t r;
    r.kind  = ROW_ITEM;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    r.idx   = CFG_OPEN_DELAY;
    r.val   = '0;
    return r;
  endfunction

  function automatic row_t row_cfg(cfg_index_e idx, logic [CfgWidth-1:0] val);
    row_t r;
    r.kind  = ROW_CFG;
    r.item  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic wait_drain();
    while (valve_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgWidth-1:0] val);
    in_valid <= 1'b0;
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OPEN_DELAY:  cfg_open  = val;
      CFG_CLOSE_DELAY: cfg_close = val;
      CFG_ACTIVE_MASK: cfg_mask  = val;
      default: ;
    endcase
  endtask

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    int        gap;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    pred = predict_valve(it);
    valve_result_q.push_back(typed ? want : pred);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_gap_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (valve_result_q.size() == 0) begin
        log_mismatch($sformatf("unexpected item %h", out_item_o));
      end else begin
        want = valve_result_q.pop_front();
        if (out_item_o.valve_open !== want.valve_open)
          log_mismatch($sformatf("valve_open got %b want %b",
                                 out_item_o.valve_open, want.valve_open));
        if (out_item_o.valve_commanded !== want.valve_commanded)
          log_mismatch($sformatf("valve_commanded got %b want %b",
                                 out_item_o.valve_commanded, want.valve_commanded));
        if (out_item_o.controller_state !== want.controller_state)
          log_mismatch($sformatf("controller_state got %0d want %0d",
                                 out_item_o.controller_state, want.controller_state));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    int       r;
    logic     lvl;
    pv_state  = ST_INACTIVE;
    pv_count  = '0;
    pv_code   = '0;
    pv_level  = 1'b0;
    pv_valve  = 1'b0;
    pv_cmd    = 1'b0;
    cfg_open  = ResetOpenDelay;
    cfg_close = ResetCloseDelay;
    cfg_mask  = ResetActiveMask;

    // after reset: open 200, close 0, mask codes 2..7
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b0, ST_INACTIVE)));
    dir_rows.push_back(row_in(mk_item(OP_UNUSED, 4'd15, 1'b1), 1'b1,
                              mk_out(1'b0, 1'b0, ST_INACTIVE)));
    // level recorded while inactive
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b1), 1'b1,
                              mk_out(1'b0, 1'b0, ST_INACTIVE)));
    // activate with level high drives the valve closed
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd2, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b1, ST_IDLE)));
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd7, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b0, ST_IDLE)));
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd7, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b0, ST_DLY_OPEN)));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b0, '0));
    // level change cancels the pending open
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_cfg(CFG_OPEN_DELAY, 16'd0));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b1,
                              mk_out(1'b1, 1'b1, ST_IDLE)));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b1, ST_IDLE)));
    // oversized close delay loads as the cap
    dir_rows.push_back(row_cfg(CFG_CLOSE_DELAY, 16'hFFFF));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd0, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd0, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd0, 1'b0), 1'b1,
                              mk_out(1'b0, 1'b1, ST_INACTIVE)));
    dir_rows.push_back(row_cfg(CFG_ACTIVE_MASK, 16'h8001));
    // deactivate while inactive is ignored
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd1, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd15, 1'b0), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_PROC, 4'd12, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_TICK, 4'd15, 1'b1), 1'b0, '0));
    dir_rows.push_back(row_in(mk_item(OP_LEVEL, 4'd15, 1'b0), 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_OPEN_DELAY, 16'd0);
          write_reg(CFG_CLOSE_DELAY, 16'(DelayLimit));
          write_reg(CFG_ACTIVE_MASK, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_OPEN_DELAY, 16'hFFFF);
          write_reg(CFG_CLOSE_DELAY, 16'd0);
          write_reg(CFG_ACTIVE_MASK, 16'h0000);
        end
        2: begin
          write_reg(CFG_OPEN_DELAY, 16'd1);
          write_reg(CFG_CLOSE_DELAY, 16'd1);
          write_reg(CFG_ACTIVE_MASK, ResetActiveMask);
        end
        default: begin
          write_reg(CFG_OPEN_DELAY, 16'($urandom_range(0, 15)));
          write_reg(CFG_CLOSE_DELAY, 16'($urandom_range(0, 15)));
          write_reg(CFG_ACTIVE_MASK, 16'($urandom_range(0, 65535)));
        end
      endcase

      if (ph == RAND_PHASES - 1 || ph % 3 == 0) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end else begin
        tx_gap_pct = 12;
        rx_gap_pct = 10;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 40) hold_armed = 1'b1;
        it = mk_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        // mostly ticks so that countdowns run out; levels mostly toggle
        if (r < 60) begin
          it.opcode = OP_TICK;
        end else if (r < 76) begin
          lvl = ($urandom_range(0, 4) != 0) ? ~pv_level : pv_level;
          it.opcode     = OP_LEVEL;
          it.level_high = lvl;
        end else if (r < 94) begin
          it.opcode = OP_PROC;
        end else begin
          it.opcode = OP_UNUSED;
        end
        push_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dvsc_pkg.sv
hdl/dvsc_cfg.sv
hdl/dvsc_core.sv
hdl/dvsc_out.sv
hdl/delayed_valve_supply_controller.sv
test/tb_top.sv
